@@ sv/uwic_pkg.sv @@
// Package with the shared control struct of the unique-value insertion chain.
`timescale 1ns / 1ps
package uwic_pkg;

  // Control broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic clear;   // drop all stored distinct values
    logic insert;  // a stored element is presented on the key bus
    logic hit;     // the key already sits in some cell
  } cell_ctrl_t;

endpackage

@@ sv/uwic_cell.sv @@
// One cell of the sorted insertion chain: a distinct value, its count and a valid bit.
`timescale 1ns / 1ps
module uwic_cell #(
  parameter int VW = 32,
  parameter int CW = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  uwic_pkg::cell_ctrl_t ctrl_i,
  input  logic [VW-1:0]      key_i,
  input  logic               left_gt_i,
  input  logic               left_vld_i,
  input  logic [VW-1:0]      left_val_i,
  input  logic [CW-1:0]      left_cnt_i,
  output logic [VW-1:0]      val_o,
  output logic [CW-1:0]      cnt_o,
  output logic               vld_o,
  output logic               gt_o,
  output logic               eq_o
);

  logic [VW-1:0] val_q, val_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          vld_q, vld_d;

  assign eq_o = vld_q && (val_q == key_i);
  // An empty cell counts as greater, so new values land behind the filled part.
  assign gt_o = !vld_q || ($signed(val_q) > $signed(key_i));

  always_comb begin
    val_d = val_q;
    cnt_d = cnt_q;
    vld_d = vld_q;
    if (ctrl_i.clear) begin
      vld_d = 1'b0;
      cnt_d = '0;
    end else if (ctrl_i.insert) begin
      if (ctrl_i.hit) begin
        if (eq_o) cnt_d = cnt_q + CW'(1);
      end else if (gt_o) begin
        if (left_gt_i) begin
          // Shifting right: an empty neighbor keeps this cell empty.
          vld_d = left_vld_i;
          val_d = left_val_i;
          cnt_d = left_cnt_i;
        end else begin
          vld_d = 1'b1;
          val_d = key_i;
          cnt_d = CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      vld_q <= vld_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign cnt_o = cnt_q;
  assign vld_o = vld_q;

endmodule

@@ sv/unique_with_inverse_and_counts.sv @@
// Top level: loads a set, keeps its distinct values sorted in a cell chain, then emits results.
`timescale 1ns / 1ps
// Load phase: one element is taken per cycle; each one that fits goes into the element memory
// and into the sorted insertion chain of CAPACITY cells in that same cycle; the rest set overflow.
// Burst phase: after the last element, one result per stored element, passing through memory
// read, chain compare and output register, and held there while the output side stalls.
// After the final result is taken, a clear state empties the chain and loading resumes.
// Reset clears the chain, the counters and the sequencer; the element memory is not reset.
module unique_with_inverse_and_counts #(
  parameter int CAPACITY    = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Slave side request: value.
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_tdata_i,
  input  logic                             s_tlast_i,
  // Master side request, tdata from the lowest bit up: inverse_rank[4:0],
  // unique_value[36:5], unique_count[42:37], num_unique[48:43], overflow[49], zero fill.
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [55:0] m_tdata_o,
  output logic        m_tlast_o,   // last_result
  output logic        m_tuser_o    // unique_valid
);

  localparam int VW = VALUE_WIDTH;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [2:0] {
    ST_LOAD, ST_READ, ST_CMP, ST_OUT, ST_CLR
  } state_e;

  state_e        state_q;
  logic [CW-1:0] load_q, idx_q, dist_q;
  logic          drop_q;
  logic [VW-1:0] mem [CAPACITY];
  logic [VW-1:0] rdata_q;

  logic [VW-1:0] in_val;
  logic          acc, store;
  logic [VW-1:0] key;
  uwic_pkg::cell_ctrl_t ctrl;

  logic [VW-1:0] cval [CAPACITY];
  logic [CW-1:0] ccnt [CAPACITY];
  logic [CAPACITY-1:0] cvld, cgt, ceq;

  assign in_val     = s_tdata_i[VW-1:0];
  assign s_tready_o = (state_q == ST_LOAD);
  assign acc        = s_tvalid_i && s_tready_o;
  assign store      = acc && (load_q < CW'(CAPACITY));
  // During the burst the key bus carries the element read back from memory.
  assign key        = (state_q == ST_LOAD) ? in_val : rdata_q;

  assign ctrl.clear  = (state_q == ST_CLR);
  assign ctrl.insert = store;
  assign ctrl.hit    = |ceq;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic          lgt;
    logic          lvld;
    logic [VW-1:0] lval;
    logic [CW-1:0] lcnt;
    if (i == 0) begin : g_head
      assign lgt  = 1'b0;
      assign lvld = 1'b0;
      assign lval = '0;
      assign lcnt = '0;
    end else begin : g_body
      assign lgt  = cgt[i-1];
      assign lvld = cvld[i-1];
      assign lval = cval[i-1];
      assign lcnt = ccnt[i-1];
    end
    uwic_cell #(.VW(VW), .CW(CW)) u_cell (
      .clk_i, .rst_ni,
      .ctrl_i(ctrl), .key_i(key),
      .left_gt_i(lgt), .left_vld_i(lvld), .left_val_i(lval), .left_cnt_i(lcnt),
      .val_o(cval[i]), .cnt_o(ccnt[i]), .vld_o(cvld[i]),
      .gt_o(cgt[i]), .eq_o(ceq[i])
    );
  end

  // The matching cell is one-hot, so its index is an OR of the selected indices.
  logic [IW-1:0] rank;
  always_comb begin
    rank = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (ceq[i]) rank = rank | IW'(i);
    end
  end

  logic [IW-1:0] ridx;
  logic          uvalid;
  assign ridx   = idx_q[IW-1:0];
  assign uvalid = (idx_q < dist_q);

  always_ff @(posedge clk_i) begin
    if (store) mem[load_q[IW-1:0]] <= in_val;
    if (state_q == ST_READ) rdata_q <= mem[ridx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_q     <= '0;
      idx_q      <= '0;
      dist_q     <= '0;
      drop_q     <= 1'b0;
      m_tvalid_o <= 1'b0;
      m_tdata_o  <= '0;
      m_tlast_o  <= 1'b0;
      m_tuser_o  <= 1'b0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (acc) begin
            if (store) begin
              load_q <= load_q + CW'(1);
              if (!ctrl.hit) dist_q <= dist_q + CW'(1);
            end else begin
              drop_q <= 1'b1;
            end
            if (s_tlast_i) begin
              idx_q   <= '0;
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: state_q <= ST_CMP;
        ST_CMP: begin
          m_tvalid_o <= 1'b1;
          m_tdata_o  <= {6'd0, drop_q, 6'(dist_q),
                         uvalid ? 6'(ccnt[ridx]) : 6'd0,
                         uvalid ? 32'(cval[ridx]) : 32'd0,
                         5'(rank)};
          m_tuser_o  <= uvalid;
          m_tlast_o  <= (idx_q + CW'(1) == load_q);
          state_q    <= ST_OUT;
        end
        ST_OUT: begin
          if (m_tready_i) begin
            m_tvalid_o <= 1'b0;
            if (m_tlast_o) begin
              state_q <= ST_CLR;
            end else begin
              idx_q   <= idx_q + CW'(1);
              state_q <= ST_READ;
            end
          end
        end
        ST_CLR: begin
          load_q  <= '0;
          dist_q  <= '0;
          drop_q  <= 1'b0;
          state_q <= ST_LOAD;
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  // The distinct count must track the number of occupied cells.
  a_dist_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cvld) == int'(dist_q))
    else $error("distinct total differs from occupied cells");

  a_dist_le_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_q <= load_q)
    else $error("more distinct values than stored elements");

  a_out_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) == m_tvalid_o)
    else $error("output valid out of step with sequencer");

  a_no_take_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> !s_tready_o)
    else $error("input accepted during burst");

endmodule
